[design/gfr_pkg.sv]
// Package for the gain frame receiver: frame layout constants, gain limits,
// shared types and the clamp function.
// Depends on nothing; used by every file of the block.
package gfr_pkg;

   // Number of payload words in a frame.
   localparam int GAIN_WORDS = 10;
   // Number of gain slots that are staged and applied.
   localparam int SLOTS      = 10;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 12;
   localparam int GAIN_W     = 10;
   localparam int SUM_W      = 16;
   localparam int SLOT_IDX_W = $clog2(SLOTS);

   // Position counter covers header, payload and both check bytes.
   localparam int POS_W = $clog2(2 * GAIN_WORDS + 4);
   localparam logic [POS_W-1:0] POS_HDR0    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR1    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_PAY_END = POS_W'(2 + 2 * GAIN_WORDS);
   localparam logic [POS_W-1:0] POS_CHK_HI  = POS_W'(3 + 2 * GAIN_WORDS);

   localparam logic [BYTE_W-1:0] HDR0_BYTE = 8'h20;
   localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'h40;

   // Channel widths.
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 80;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [GAIN_W-1:0] gain_type;
   typedef word_type [SLOTS-1:0] word_array_type;
   typedef gain_type [SLOTS-1:0] gain_array_type;

   // Upper limit of each gain slot, slot 0 first.
   localparam gain_type GAIN_LIMIT [SLOTS] = '{
      10'd300, 10'd100, 10'd300, 10'd100, 10'd100,
      10'd50,  10'd100, 10'd50,  10'd1000, 10'd100
   };

   // Frame end report from the parser to the top level.
   typedef struct packed {
      logic done;
      logic good;
   } frame_event_type;

   // Limit one staged word to the ceiling of its slot.
   function automatic gain_type clamp_gain(input word_type value, input gain_type limit);
      gain_type result;
      if (value > WORD_W'(limit)) begin
         result = limit;
      end else begin
         result = GAIN_W'(value);
      end
      return result;
   endfunction

endpackage

[design/gfr_frame_parser.sv]
// Byte-level frame parser: tracks the position in the frame, the running sum,
// stages payload words and reports the check result on the last byte.
// Depends on gfr_pkg.
module gfr_frame_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              rx_byte,
   output gfr_pkg::word_array_type staged_words,
   output gfr_pkg::frame_event_type frame_event
);
   import gfr_pkg::*;

   logic [POS_W-1:0]  byte_position_ff, byte_position_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0] low_byte_hold_ff, low_byte_hold_in;
   logic [BYTE_W-1:0] check_low_byte_ff, check_low_byte_in;
   word_array_type    staged_words_ff;

   logic [POS_W-1:0]  pay_offset;
   logic [POS_W-2:0]  word_index;
   logic              stage_write;
   logic [SUM_W-1:0]  check_value;

   assign pay_offset  = byte_position_ff - POS_W'(2);
   assign word_index  = pay_offset[POS_W-1:1];
   assign check_value = {rx_byte, check_low_byte_ff};

   // Next state of the frame walk for the byte that is offered.
   always_comb begin
      byte_position_in  = byte_position_ff;
      running_sum_in    = running_sum_ff;
      low_byte_hold_in  = low_byte_hold_ff;
      check_low_byte_in = check_low_byte_ff;
      stage_write       = 1'b0;
      frame_event       = '0;
      if (byte_position_ff == POS_HDR0) begin
         if (rx_byte == HDR0_BYTE) begin
            running_sum_in   = SUM_W'(HDR0_BYTE);
            byte_position_in = POS_HDR1;
         end else begin
            byte_position_in = POS_HDR0;
         end
      end else if (byte_position_ff == POS_HDR1) begin
         if (rx_byte == HDR1_BYTE) begin
            running_sum_in   = running_sum_ff + SUM_W'(HDR1_BYTE);
            byte_position_in = POS_W'(2);
         end else begin
            byte_position_in = POS_HDR0;
         end
      end else if (byte_position_ff < POS_PAY_END) begin
         running_sum_in   = running_sum_ff + SUM_W'(rx_byte);
         byte_position_in = byte_position_ff + POS_W'(1);
         if (!pay_offset[0]) begin
            low_byte_hold_in = rx_byte;
         end else begin
            stage_write = (word_index < (POS_W-1)'(SLOTS));
         end
      end else if (byte_position_ff == POS_PAY_END) begin
         check_low_byte_in = rx_byte;
         byte_position_in  = byte_position_ff + POS_W'(1);
      end else if (byte_position_ff == POS_CHK_HI) begin
         // The expected check is 0xFFFF minus the sum, i.e. its complement.
         frame_event.done = 1'b1;
         frame_event.good = (check_value == ~running_sum_ff);
         byte_position_in = POS_HDR0;
      end else begin
         byte_position_in = POS_HDR0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= POS_HDR0;
         running_sum_ff    <= '0;
         low_byte_hold_ff  <= '0;
         check_low_byte_ff <= '0;
      end else if (byte_accept) begin
         byte_position_ff  <= byte_position_in;
         running_sum_ff    <= running_sum_in;
         low_byte_hold_ff  <= low_byte_hold_in;
         check_low_byte_ff <= check_low_byte_in;
      end
   end

   // Staged payload words; every slot is written before a check can use it.
   always_ff @(posedge clock) begin
      if (byte_accept && stage_write) begin
         staged_words_ff[word_index[SLOT_IDX_W-1:0]] <=
            WORD_W'({rx_byte, low_byte_hold_ff});
      end
   end

   assign staged_words = staged_words_ff;

endmodule

[design/gain_frame_receiver.sv]
// Gain frame receiver top level: parser, held gains and the result register.
// Depends on gfr_pkg and gfr_frame_parser.
//
// Usage:
//   The req_ channel carries one received byte per transaction. A frame is the
//   header 0x20 0x40, twenty payload bytes that form ten little-endian 12-bit
//   words, then a 16-bit check sent low byte first. The rsp_ channel carries
//   one transaction per frame, on the check's high byte: frame_good and the
//   ten held gains, updated first when the check matched.
//   A result is registered and shown in the cycle after the byte that ends the frame.
//   Throughput: one byte per cycle while no pending result is held back; the
//   position counter and the 16-bit running sum update on each accepted byte.
//   A byte that breaks the header returns the parser to the start and is
//   dropped without a result.
//   Reset clears the position, the sum, the held gains and the result valid
//   flag; staged words and the result payload are not cleared.
//   When the receiver stalls, the pending result holds in the output
//   register and req_tready drops until it is taken; a result taken in the
//   same cycle frees the register for the next byte.
module gain_frame_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] rx_byte
   input  logic [gfr_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] frame_good, [9:1] roll_angle_p, [16:10] roll_angle_d,
   // [25:17] pitch_angle_p, [32:26] pitch_angle_d, [39:33] roll_rate_p,
   // [45:40] roll_rate_d, [52:46] pitch_rate_p, [58:53] pitch_rate_d,
   // [68:59] yaw_rate_p, [75:69] yaw_rate_d, [79:76] zero
   output logic [gfr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gfr_pkg::*;

   logic                   req_accept;
   word_array_type         staged_words;
   frame_event_type        frame_event;
   gain_array_type         applied_gains_ff, applied_gains_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // A byte is taken whenever the result register is free or being emptied.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   gfr_frame_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (req_accept),
      .rx_byte      (req_tdata[7:0]),
      .staged_words (staged_words),
      .frame_event  (frame_event)
   );

   // Apply clamped staged words when a frame ends with a matching check.
   always_comb begin
      applied_gains_in = applied_gains_ff;
      if (req_accept && frame_event.done && frame_event.good) begin
         for (int i = 0; i < SLOTS; i++) begin
            applied_gains_in[i] = clamp_gain(staged_words[i], GAIN_LIMIT[i]);
         end
      end
   end

   // Result register load and release.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (req_accept && frame_event.done) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {4'b0000,
                          applied_gains_in[9][6:0],
                          applied_gains_in[8][9:0],
                          applied_gains_in[7][5:0],
                          applied_gains_in[6][6:0],
                          applied_gains_in[5][5:0],
                          applied_gains_in[4][6:0],
                          applied_gains_in[3][6:0],
                          applied_gains_in[2][8:0],
                          applied_gains_in[1][6:0],
                          applied_gains_in[0][8:0],
                          frame_event.good};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_gains_ff <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         applied_gains_ff <= applied_gains_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[design/gfr_port_checker.sv]
// Port-level checks for the gain frame receiver, bound to the top level.
// Depends on gfr_pkg and on the gain_frame_receiver port list.
module gfr_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gfr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gfr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import gfr_pkg::*;

   // A pending result transaction is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction dropped or changed while stalled");

   // With the result register empty the block always takes a byte.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while no result was pending");

   // A new result transaction follows an accepted byte in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) |->
         $past(req_tvalid && req_tready))
      else $error("result transaction appeared without an input byte");

   // Reported gains never exceed their slot limits; pad bits stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:1] <= 9'd300 && rsp_tdata[16:10] <= 7'd100 &&
         rsp_tdata[25:17] <= 9'd300 && rsp_tdata[32:26] <= 7'd100 &&
         rsp_tdata[39:33] <= 7'd100 && rsp_tdata[45:40] <= 6'd50 &&
         rsp_tdata[52:46] <= 7'd100 && rsp_tdata[58:53] <= 6'd50 &&
         rsp_tdata[68:59] <= 10'd1000 && rsp_tdata[75:69] <= 7'd100 &&
         rsp_tdata[79:76] == 4'd0)
      else $error("reported gain outside its limit");

endmodule

bind gain_frame_receiver gfr_port_checker u_port_checker (.*);
